### hdl/jkse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON keyed string extractor package
// Shared payload types, result codes, parser phases and sizing constants.
// ----------------------------------------------------------------------------
package jkse_pkg;

   localparam int MAX_KEY_BYTES_DEF = 14;
   localparam int KEY_REG_BYTES     = 14;
   localparam int KEY_IDX_W         = $clog2(KEY_REG_BYTES);
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 64;
   localparam int KEY_LOW_W         = 64;
   localparam int KEY_HIGH_W        = 48;
   localparam int KEY_LEN_W         = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LEN  = 2'd2;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   localparam logic [7:0] CH_QUOTE = 8'h22;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_SPACE,
      PH_STRING,
      PH_ESCAPE,
      PH_HEX,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctrl_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef logic [KEY_REG_BYTES-1:0][7:0] key_chars_type;

endpackage

### hdl/jkse_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match window cell
// Holds one byte of the sliding window and compares the byte shifting into it
// against the character that the key marker expects at this position.
// ----------------------------------------------------------------------------
module jkse_cell #(
   parameter int IDX   = 0,
   parameter int LEN_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  jkse_pkg::win_ctrl_type ctrl,
   input  logic [7:0]             byte_in,
   input  logic [LEN_W-1:0]       key_len,
   input  jkse_pkg::key_chars_type key_chars,
   output logic [7:0]             byte_out,
   output logic                   hit
);
   import jkse_pkg::*;

   logic [7:0]       win_ff;
   logic [7:0]       win_in;
   logic [7:0]       expected;
   logic [LEN_W-1:0] kidx;
   logic             care;

   always_comb begin
      kidx     = key_len - LEN_W'(IDX);
      care     = 1'b1;
      expected = CH_QUOTE;
      if (IDX == 0 || IDX == int'(key_len) + 1) begin
         expected = CH_QUOTE;
      end else if (IDX <= int'(key_len)) begin
         if (int'(kidx) < KEY_REG_BYTES) begin
            expected = key_chars[KEY_IDX_W'(kidx)];
         end else begin
            expected = 8'h00;
         end
      end else begin
         care = 1'b0;
      end
      hit = !care || (byte_in == expected);
   end

   always_comb begin
      win_in = win_ff;
      if (ctrl.clear) begin
         win_in = 8'h00;
      end else if (ctrl.shift) begin
         win_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 8'h00;
      end else begin
         win_ff <= win_in;
      end
   end

   assign byte_out = win_ff;

endmodule

### hdl/jkse_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value parser
// Tracks the phase after the key marker, unescapes the string value and
// forms the result for each accepted beat.
// ----------------------------------------------------------------------------
module jkse_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  jkse_pkg::req_type      req,
   input  logic                   marker,
   output jkse_pkg::win_ctrl_type ctrl,
   output jkse_pkg::result_type   res
);
   import jkse_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] acc_next;
   logic [2:0]  cnt_next;
   logic [4:0]  digit;
   logic [7:0]  c;
   logic        has_res;
   logic [1:0]  kind;
   logic [7:0]  val;

   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] d;
      d = 5'h10;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         d = 5'(ch - 8'h30);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         d = 5'(ch - 8'h57);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         d = 5'(ch - 8'h37);
      end
      return d;
   endfunction

   always_comb begin
      c        = req.in_byte;
      digit    = hex_digit(c);
      acc_next = {acc_ff[11:0], digit[3:0]};
      cnt_next = cnt_ff + 3'd1;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      has_res  = 1'b0;
      kind     = KIND_BYTE;
      val      = 8'h00;
      unique case (phase_ff)
         PH_SEARCH: begin
            if (marker) begin
               phase_in = PH_COLON;
            end
         end
         PH_COLON: begin
            if (c == 8'h3a) begin
               phase_in = PH_SPACE;
            end
         end
         PH_SPACE: begin
            if (c == 8'h20 || c == 8'h0a || c == 8'h0d || c == 8'h09) begin
               phase_in = PH_SPACE;
            end else if (c == CH_QUOTE) begin
               phase_in = PH_STRING;
            end else begin
               phase_in = PH_DONE;
               has_res  = 1'b1;
               kind     = KIND_FAIL;
            end
         end
         PH_STRING: begin
            has_res = 1'b1;
            if (c == CH_QUOTE) begin
               phase_in = PH_DONE;
               kind     = KIND_OK;
            end else if (c == 8'h5c) begin
               phase_in = PH_ESCAPE;
               has_res  = 1'b0;
            end else if (c < 8'h20) begin
               phase_in = PH_DONE;
               kind     = KIND_FAIL;
            end else begin
               val = c;
            end
         end
         PH_ESCAPE: begin
            phase_in = PH_STRING;
            has_res  = 1'b1;
            case (c) inside
               8'h22, 8'h5c, 8'h2f: val = c;
               8'h62: val = 8'h08;
               8'h66: val = 8'h0c;
               8'h6e: val = 8'h0a;
               8'h72: val = 8'h0d;
               8'h74: val = 8'h09;
               8'h75: begin
                  phase_in = PH_HEX;
                  has_res  = 1'b0;
                  acc_in   = 16'h0000;
                  cnt_in   = 3'd0;
               end
               default: begin
                  phase_in = PH_DONE;
                  kind     = KIND_FAIL;
               end
            endcase
         end
         PH_HEX: begin
            if (digit[4]) begin
               phase_in = PH_DONE;
               has_res  = 1'b1;
               kind     = KIND_FAIL;
            end else begin
               acc_in = acc_next;
               cnt_in = cnt_next;
               if (cnt_next == 3'd4) begin
                  cnt_in  = 3'd0;
                  has_res = 1'b1;
                  if (acc_next[15:8] != 8'h00) begin
                     phase_in = PH_DONE;
                     kind     = KIND_FAIL;
                  end else begin
                     phase_in = PH_STRING;
                     val      = acc_next[7:0];
                  end
               end
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
      if (req.last) begin
         phase_in = PH_SEARCH;
         acc_in   = 16'h0000;
         cnt_in   = 3'd0;
         if (phase_ff == PH_DONE) begin
            has_res = 1'b0;
         end else if (!has_res || kind == KIND_BYTE) begin
            has_res = 1'b1;
            kind    = KIND_FAIL;
            val     = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         acc_ff   <= 16'h0000;
         cnt_ff   <= 3'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign ctrl.shift         = accept && (phase_ff == PH_SEARCH);
   assign ctrl.clear         = accept && req.last;
   assign res.valid          = accept && has_res;
   assign res.data.out_byte  = val;
   assign res.data.kind      = kind;

endmodule

### hdl/json_keyed_string_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON keyed string extractor
// Finds a quoted key in a byte stream and emits the unescaped string value.
// ----------------------------------------------------------------------------
// The block takes one text byte per beat, one beat every cycle unless a held
// result stalls it, and gives at most one result beat per input beat, in the
// cycle after the input beat: a decoded byte, a success at the closing quote,
// or a failure. The key marker is found by a row of MAX_KEY_BYTES+2 window
// cells that shift and compare in the same cycle, so the search runs at full
// byte rate; the result sits in a registered output stage, and input is taken
// whenever that stage is empty or being drained. No clearing pass follows
// reset, and the key registers may be written whenever the block is idle.
module json_keyed_string_extractor #(
   parameter int MAX_KEY_BYTES = jkse_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  jkse_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output jkse_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [jkse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jkse_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import jkse_pkg::*;

   localparam int WIN_DEPTH = MAX_KEY_BYTES + 2;
   localparam int LEN_W     = $clog2(MAX_KEY_BYTES + 1);

   logic [KEY_LOW_W-1:0]  key_low_ff;
   logic [KEY_HIGH_W-1:0] key_high_ff;
   logic [KEY_LEN_W-1:0]  key_len_ff;
   logic [LEN_W-1:0]      eff_len;
   key_chars_type         key_chars;

   logic                  req_fire;
   win_ctrl_type          ctrl;
   result_type            res;
   logic [WIN_DEPTH-1:0]  hits;
   logic [WIN_DEPTH-1:0][7:0] win;
   logic [WIN_DEPTH-1:0][7:0] cell_in;
   logic                  marker;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata[KEY_LOW_W-1:0];
            CSR_KEY_HIGH: key_high_ff <= csr_wdata[KEY_HIGH_W-1:0];
            CSR_KEY_LEN:  key_len_ff  <= csr_wdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < KEY_REG_BYTES; k++) begin
         if (k < 8) begin
            key_chars[k] = key_low_ff[8*k +: 8];
         end else begin
            key_chars[k] = key_high_ff[8*(k-8) +: 8];
         end
      end
      if (int'(key_len_ff) > MAX_KEY_BYTES) begin
         eff_len = LEN_W'(MAX_KEY_BYTES);
      end else begin
         eff_len = LEN_W'(key_len_ff);
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   genvar gi;
   generate
      for (gi = 0; gi < WIN_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign cell_in[gi] = req_data.in_byte;
         end else begin : g_body
            assign cell_in[gi] = win[gi-1];
         end
         jkse_cell #(
            .IDX   (gi),
            .LEN_W (LEN_W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .byte_in   (cell_in[gi]),
            .key_len   (eff_len),
            .key_chars (key_chars),
            .byte_out  (win[gi]),
            .hit       (hits[gi])
         );
      end
   endgenerate

   assign marker = &hits;

   jkse_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (req_fire),
      .req    (req_data),
      .marker (marker),
      .ctrl   (ctrl),
      .res    (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A held result beat must stall the input side.
   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while a result beat is stalled");

   // The window is empty after the final byte of a text.
   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.last |=> win == '0)
      else $error("match window not cleared after last beat");

   // Only a decoded byte carries a nonzero byte value.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_BYTE |-> rsp_data.out_byte == 8'h00)
      else $error("nonzero byte on a status result");

   // A result beat is loaded only at an accepted input beat.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      !req_fire && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("result beat without an input beat");

endmodule
